@@ rtl/vp2w_pkg.sv @@
package vp2w_pkg;

  typedef struct packed {
    logic               opcode;
    logic [4:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] obj_x;
    logic signed [31:0] obj_y;
    logic signed [31:0] obj_z;
  } in_word_t;

  typedef struct packed {
    logic               projected;
    logic signed [31:0] win_x;
    logic signed [31:0] win_y;
  } out_word_t;

  typedef struct packed {
    logic               vld;
    logic signed [31:0] clip_x;
    logic signed [31:0] clip_y;
    logic signed [32:0] w;
  } clip_word_t;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PROJECT = 1'b1;

  localparam logic [1:0] CFG_VP_X      = 2'd0;
  localparam logic [1:0] CFG_VP_Y      = 2'd1;
  localparam logic [1:0] CFG_VP_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_VP_HEIGHT = 2'd3;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] res;
    if (x > 64'sh0000_0000_7FFF_FFFF) begin
      res = 32'sh7FFF_FFFF;
    end else if (x < -64'sh0000_0000_8000_0000) begin
      res = 32'sh8000_0000;
    end else begin
      res = x[31:0];
    end
    return res;
  endfunction

endpackage

@@ rtl/vp2w_xform.sv @@
module vp2w_xform #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  vp2w_pkg::in_word_t     in_word,
  output vp2w_pkg::clip_word_t   clip_o
);

  logic signed [31:0] tab_r [32];

  // stage a: vertex
  logic               a_vld_r;
  logic signed [31:0] a_obj_r [3];

  // stage b: modelview products, coefficient snapshot
  logic               b_vld_r;
  logic signed [63:0] b_prod_r [4][3];
  logic signed [31:0] b_off_r [4];
  logic signed [31:0] b_pj_r [2][4];
  logic signed [63:0] b_prod_nxt [4][3];

  // stage c: eye coordinates
  logic               c_vld_r;
  logic signed [31:0] c_eye_r [4];
  logic signed [31:0] c_pj_r [2][4];
  logic signed [32:0] c_w_r;
  logic signed [31:0] c_eye_nxt [4];

  // stage d: projection products
  logic               d_vld_r;
  logic signed [63:0] d_prod_r [2][4];
  logic signed [32:0] d_w_r;
  logic signed [63:0] d_prod_nxt [2][4];

  // stage e: clip
  logic               e_vld_r;
  logic signed [31:0] e_clip_r [2];
  logic signed [32:0] e_w_r;
  logic signed [31:0] e_clip_nxt [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 32; i++) begin
        tab_r[i] <= '0;
      end
    end else if (en && in_valid && in_word.opcode == vp2w_pkg::OP_LOAD) begin
      tab_r[in_word.coef_index] <= in_word.coef_value;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        b_prod_nxt[r][c] = (tab_r[r + 4 * c] * a_obj_r[c]) >>> FRAC_BITS;
      end
      c_eye_nxt[r] = vp2w_pkg::sat32(b_prod_r[r][0] + b_prod_r[r][1] + b_prod_r[r][2]
                                     + 64'(b_off_r[r]));
    end
    for (int r = 0; r < 2; r++) begin
      for (int c = 0; c < 4; c++) begin
        d_prod_nxt[r][c] = (c_pj_r[r][c] * c_eye_r[c]) >>> FRAC_BITS;
      end
      e_clip_nxt[r] = vp2w_pkg::sat32(d_prod_r[r][0] + d_prod_r[r][1] + d_prod_r[r][2]
                                      + d_prod_r[r][3]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid && in_word.opcode == vp2w_pkg::OP_PROJECT;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
      e_vld_r <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_obj_r[0] <= in_word.obj_x;
      a_obj_r[1] <= in_word.obj_y;
      a_obj_r[2] <= in_word.obj_z;
      b_prod_r   <= b_prod_nxt;
      for (int r = 0; r < 4; r++) begin
        b_off_r[r] <= tab_r[12 + r];
      end
      for (int r = 0; r < 2; r++) begin
        for (int c = 0; c < 4; c++) begin
          b_pj_r[r][c] <= tab_r[16 + r + 4 * c];
        end
      end
      c_eye_r  <= c_eye_nxt;
      c_pj_r   <= b_pj_r;
      c_w_r    <= -33'(c_eye_nxt[2]);
      d_prod_r <= d_prod_nxt;
      d_w_r    <= c_w_r;
      e_clip_r <= e_clip_nxt;
      e_w_r    <= d_w_r;
    end
  end

  assign clip_o.vld    = e_vld_r;
  assign clip_o.clip_x = e_clip_r[0];
  assign clip_o.clip_y = e_clip_r[1];
  assign clip_o.w      = e_w_r;

endmodule

@@ rtl/vp2w_div.sv @@
module vp2w_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [31:0]       num,
  input  logic signed [32:0]       den,
  output logic signed [32+FRAC_BITS:0] quo
);

  localparam int NQ = 32 + FRAC_BITS;

  logic [31:0]   rem_r [NQ+1];
  logic [NQ-1:0] dq_r  [NQ+1];
  logic [31:0]   dv_r  [NQ+1];
  logic          ng_r  [NQ+1];

  logic [32:0] num_abs;
  logic [32:0] den_abs;

  assign num_abs = num[31] ? -33'(num) : 33'(num);
  assign den_abs = den[32] ? -den : den;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      dq_r[0]  <= {num_abs[31:0], {FRAC_BITS{1'b0}}};
      dv_r[0]  <= den_abs[31:0];
      ng_r[0]  <= num[31] ^ den[32];
    end
  end

  for (genvar i = 0; i < NQ; i++) begin : g_step
    logic [32:0] rem2;
    logic [32:0] diff;
    logic        ge;
    assign rem2 = {rem_r[i], dq_r[i][NQ-1]};
    assign diff = rem2 - {1'b0, dv_r[i]};
    assign ge   = rem2 >= {1'b0, dv_r[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= ge ? diff[31:0] : rem2[31:0];
        dq_r[i+1]  <= {dq_r[i][NQ-2:0], ge};
        dv_r[i+1]  <= dv_r[i];
        ng_r[i+1]  <= ng_r[i];
      end
    end
  end

  assign quo = ng_r[NQ] ? -$signed({1'b0, dq_r[NQ]}) : $signed({1'b0, dq_r[NQ]});

endmodule

@@ rtl/vp2w_view.sv @@
module vp2w_view #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [32+FRAC_BITS:0] ndc,
  input  logic [15:0]                  size,
  input  logic signed [15:0]           origin,
  output logic signed [31:0]           win
);

  localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] LIM = 64'sd1 <<< 46;

  logic signed [63:0] t_sum;
  logic signed [47:0] t_r;
  logic signed [47:0] t_nxt;
  logic signed [63:0] m_r;
  logic signed [31:0] win_r;

  assign t_sum = 64'(ndc) + ONE;

  always_comb begin
    if (t_sum > LIM) begin
      t_nxt = LIM[47:0];
    end else if (t_sum < -LIM) begin
      t_nxt = -(LIM[47:0]);
    end else begin
      t_nxt = t_sum[47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r   <= t_nxt;
      m_r   <= t_r * $signed({1'b0, size});
      win_r <= vp2w_pkg::sat32((m_r >>> 1) + (64'(origin) <<< FRAC_BITS));
    end
  end

  assign win = win_r;

endmodule

@@ rtl/vertex_project_to_window_core.sv @@
// channel  direction  ports                         word
// in       input      in_valid, in_stall, in_word   load or project item
// out      output     out_valid, out_stall, out_word window position
// cfg      input      cfg_we, cfg_index, cfg_data   viewport registers
//
// one item per cycle unless out_stall holds the pipe; a project word passes
// through 5 transform stages, 33 + FRAC_BITS divider stages, 3 viewport stages
// load words write the table on acceptance and give no output
// synchronous active-low reset clears the table, viewport and valid bits
// the whole pipe holds while the output word is stalled
module vertex_project_to_window_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  vp2w_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output vp2w_pkg::out_word_t  out_word,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  localparam int NQ  = 32 + FRAC_BITS;
  localparam int LAT = NQ + 4;

  logic               en;
  logic signed [15:0] vp_x_r;
  logic signed [15:0] vp_y_r;
  logic [15:0]        vp_w_r;
  logic [15:0]        vp_h_r;

  vp2w_pkg::clip_word_t clip;

  logic                 dl_vld_r [LAT];
  logic                 dl_wz_r  [LAT];
  logic signed [NQ:0]   quo_x;
  logic signed [NQ:0]   quo_y;
  logic signed [31:0]   win_x;
  logic signed [31:0]   win_y;

  assign out_valid = dl_vld_r[LAT-1];
  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_x_r <= '0;
      vp_y_r <= '0;
      vp_w_r <= '0;
      vp_h_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vp2w_pkg::CFG_VP_X:      vp_x_r <= cfg_data;
        vp2w_pkg::CFG_VP_Y:      vp_y_r <= cfg_data;
        vp2w_pkg::CFG_VP_WIDTH:  vp_w_r <= cfg_data;
        vp2w_pkg::CFG_VP_HEIGHT: vp_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  vp2w_xform #(.FRAC_BITS(FRAC_BITS)) u_xform (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_word  (in_word),
    .clip_o   (clip)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) begin
        dl_vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      dl_vld_r[0] <= clip.vld;
      for (int i = 1; i < LAT; i++) begin
        dl_vld_r[i] <= dl_vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dl_wz_r[0] <= clip.w == '0;
      for (int i = 1; i < LAT; i++) begin
        dl_wz_r[i] <= dl_wz_r[i-1];
      end
    end
  end

  vp2w_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk (clk),
    .en  (en),
    .num (clip.clip_x),
    .den (clip.w),
    .quo (quo_x)
  );

  vp2w_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk (clk),
    .en  (en),
    .num (clip.clip_y),
    .den (clip.w),
    .quo (quo_y)
  );

  vp2w_view #(.FRAC_BITS(FRAC_BITS)) u_view_x (
    .clk    (clk),
    .en     (en),
    .ndc    (quo_x),
    .size   (vp_w_r),
    .origin (vp_x_r),
    .win    (win_x)
  );

  vp2w_view #(.FRAC_BITS(FRAC_BITS)) u_view_y (
    .clk    (clk),
    .en     (en),
    .ndc    (quo_y),
    .size   (vp_h_r),
    .origin (vp_y_r),
    .win    (win_y)
  );

  assign out_word.projected = !dl_wz_r[LAT-1];
  assign out_word.win_x     = dl_wz_r[LAT-1] ? '0 : win_x;
  assign out_word.win_y     = dl_wz_r[LAT-1] ? '0 : win_y;

endmodule
